>>> hw/rtl/lztd_pkg.sv
// Package for the LZ77 text-token decoder: item types, character and status
// codes, controller states, commands and status, and parameter defaults.
// No dependencies.
package lztd_pkg;

  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int MAX_RUN_DEF     = 64;

  // Accumulator widths and saturation limits of the two decimal numbers.
  localparam int DIST_W = 13;
  localparam int LEN_W  = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 13'd8191;
  localparam logic [LEN_W-1:0]  LEN_MAX  = 7'd127;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_DIST = 2'd1;
  localparam logic [1:0] STAT_TRUNC    = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_OUTSIDE,
    S_DIST,
    S_LEN,
    S_COPY
  } state_t;

  typedef struct packed {
    logic acc_clear;    // '(' opens a reference
    logic dist_take;    // byte goes to the distance number
    logic len_take;     // byte goes to the length number
    logic closed_clear; // ',' or ')' starts a fresh number
    logic lit_store;    // store and emit the input byte
    logic err_emit;     // emit the bad-distance result
    logic copy_start;   // load copy pointers, issue first history read
    logic copy_step;    // store and emit one copied byte
  } cmd_t;

  typedef struct packed {
    logic is_open;
    logic is_comma;
    logic is_close;
    logic dist_bad;
    logic len_zero;
    logic slot_free;
    logic copy_last;
  } sts_t;

endpackage

>>> hw/rtl/lztd_chan_if.sv
// Valid/ready channel carrying one item of a packed payload type.
// Depends on nothing; payload types come from lztd_pkg at instantiation.
interface lztd_chan_if #(
  parameter type item_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/lz77_text_token_decoder.sv
// LZ77 text-token decoder, top level. A literal byte appears at the output in
// the cycle after it is taken. The first history read of a reference is issued
// with ')'; each copied byte goes through the registered history read and then
// the output register, copied bytes follow one per cycle while the output slot
// is free, and the input is held off until the last byte of the run is copied.
// Parse and digit bytes are taken every cycle while the output slot is free and no copy runs.
// Synchronous reset clears parse state and pointers; history is not cleared.
module lz77_text_token_decoder #(
  parameter int WINDOW_SIZE = lztd_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_RUN     = lztd_pkg::MAX_RUN_DEF
) (
  input logic          clk,
  input logic          rst,
  lztd_chan_if.sink    token,
  lztd_chan_if.source  text
);

  lztd_pkg::cmd_t      cmd;
  lztd_pkg::sts_t      sts;
  lztd_pkg::in_item_t  in_item;
  lztd_pkg::out_item_t out_item;
  logic                out_valid;

  // Unpack the compressed byte from the input channel.
  assign in_item = token.data;

  // Controller: tracks outside / distance / length / copy and issues one
  // command set per cycle; it holds the input for the whole copy run.
  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (token.valid),
    .in_ready (token.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: decimal accumulators, distance check, history window in RAM,
  // and the output register that parts input and output handshakes.
  lztd_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_item.in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (text.ready),
    .out_item  (out_item)
  );

  // Drive the result channel from the output register.
  assign text.valid = out_valid;
  assign text.data  = out_item;

endmodule

>>> hw/rtl/lztd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lztd_ctrl.sv
// Controller of the LZ77 text-token decoder: parse mode and copy sequencing.
// Depends on lztd_pkg.
module lztd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lztd_pkg::sts_t sts,
  output lztd_pkg::cmd_t cmd
);

  lztd_pkg::state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lztd_pkg::S_OUTSIDE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = sts.slot_free && (state != lztd_pkg::S_COPY);
    accept     = in_valid && in_ready;
    unique case (state)
      lztd_pkg::S_OUTSIDE: begin
        if (accept) begin
          if (sts.is_open) begin
            cmd.acc_clear = 1'b1;
            state_next    = lztd_pkg::S_DIST;
          end else begin
            cmd.lit_store = 1'b1;
          end
        end
      end
      lztd_pkg::S_DIST: begin
        if (accept) begin
          if (sts.is_comma) begin
            cmd.closed_clear = 1'b1;
            state_next       = lztd_pkg::S_LEN;
          end else begin
            cmd.dist_take = 1'b1;
          end
        end
      end
      lztd_pkg::S_LEN: begin
        if (accept) begin
          if (sts.is_close) begin
            cmd.closed_clear = 1'b1;
            state_next       = lztd_pkg::S_OUTSIDE;
            if (sts.dist_bad) begin
              cmd.err_emit = 1'b1;
            end else if (!sts.len_zero) begin
              cmd.copy_start = 1'b1;
              state_next     = lztd_pkg::S_COPY;
            end
          end else begin
            cmd.len_take = 1'b1;
          end
        end
      end
      lztd_pkg::S_COPY: begin
        if (sts.slot_free) begin
          cmd.copy_step = 1'b1;
          if (sts.copy_last) begin
            state_next = lztd_pkg::S_OUTSIDE;
          end
        end
      end
      default: begin
        state_next = lztd_pkg::S_OUTSIDE;
      end
    endcase
  end

endmodule

>>> hw/rtl/lztd_dp.sv
// Datapath of the LZ77 text-token decoder: number accumulators, history
// pointers, history RAM and output register. Depends on lztd_pkg, lztd_ram.
module lztd_dp #(
  parameter int WINDOW_SIZE = lztd_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_RUN     = lztd_pkg::MAX_RUN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  lztd_pkg::cmd_t      cmd,
  output lztd_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output lztd_pkg::out_item_t out_item
);

  localparam int AW   = $clog2(WINDOW_SIZE);
  localparam int CW   = $clog2(WINDOW_SIZE + 1);
  localparam int SW   = CW + 1;
  localparam int MW   = (lztd_pkg::DIST_W > CW) ? lztd_pkg::DIST_W : CW;
  localparam int CNTW = $clog2(MAX_RUN + 1);
  localparam int DPW  = lztd_pkg::DIST_W + 4;
  localparam int LPW  = lztd_pkg::LEN_W + 4;

  logic [AW-1:0]               wp;
  logic [CW-1:0]               bytes_written;
  logic [lztd_pkg::DIST_W-1:0] distance_acc;
  logic [lztd_pkg::LEN_W-1:0]  length_acc;
  logic                        digits_closed;
  logic [AW-1:0]               rd;
  logic [CNTW-1:0]             count;
  logic [1:0]                  copy_status;
  logic                        dist_one;
  logic [7:0]                  last_byte;

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [DPW-1:0]              dist_prod;
  logic [LPW-1:0]              len_prod;
  logic [SW-1:0]               wp_ext;
  logic [SW-1:0]               dist_ext;
  logic [AW-1:0]               rd_start;
  logic [AW-1:0]               rd_inc;
  logic                        len_long;
  logic [lztd_pkg::LEN_W-1:0]  len_eff;
  logic                        store;
  logic [7:0]                  store_data;
  logic [7:0]                  copy_data;
  logic [7:0]                  ram_rdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;

  // Byte classes and digit arithmetic.
  always_comb begin
    is_digit     = (in_byte >= lztd_pkg::CH_ZERO) && (in_byte <= lztd_pkg::CH_NINE);
    digit        = 4'(in_byte - lztd_pkg::CH_ZERO);
    dist_prod    = DPW'(distance_acc) * DPW'(10) + DPW'(digit);
    len_prod     = LPW'(length_acc) * LPW'(10) + LPW'(digit);
  end

  // Status to the controller, distance check, copy start address and run length.
  always_comb begin
    sts.is_open   = (in_byte == lztd_pkg::CH_OPEN);
    sts.is_comma  = (in_byte == lztd_pkg::CH_COMMA);
    sts.is_close  = (in_byte == lztd_pkg::CH_CLOSE);
    sts.dist_bad  = (distance_acc == '0) ||
                    (MW'(distance_acc) > MW'(bytes_written));
    sts.len_zero  = (length_acc == '0);
    sts.slot_free = !out_valid || out_ready;
    sts.copy_last = (count == CNTW'(1));
    wp_ext       = SW'(wp);
    dist_ext     = SW'(distance_acc);
    if (wp_ext >= dist_ext) begin
      rd_start = AW'(wp_ext - dist_ext);
    end else begin
      rd_start = AW'(wp_ext + SW'(WINDOW_SIZE) - dist_ext);
    end
    rd_inc   = (rd == AW'(WINDOW_SIZE - 1)) ? '0 : rd + 1'b1;
    len_long = (length_acc > lztd_pkg::LEN_W'(MAX_RUN));
    len_eff  = len_long ? lztd_pkg::LEN_W'(MAX_RUN) : length_acc;
  end

  // A distance of one repeats the last stored byte; bypass the RAM for it.
  assign copy_data  = dist_one ? last_byte : ram_rdata;
  assign store      = cmd.lit_store || cmd.copy_step;
  assign store_data = cmd.lit_store ? in_byte : copy_data;

  assign ram_re    = cmd.copy_start || (cmd.copy_step && !sts.copy_last);
  assign ram_raddr = cmd.copy_start ? rd_start : rd_inc;

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (store),
    .waddr (wp),
    .wdata (store_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // History pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= '0;
      bytes_written <= '0;
    end else if (store) begin
      wp <= (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + 1'b1;
      if (bytes_written != CW'(WINDOW_SIZE)) begin
        bytes_written <= bytes_written + 1'b1;
      end
    end
  end

  // Number accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_acc  <= '0;
      length_acc    <= '0;
      digits_closed <= 1'b0;
    end else begin
      if (cmd.acc_clear) begin
        distance_acc  <= '0;
        length_acc    <= '0;
        digits_closed <= 1'b0;
      end
      if (cmd.closed_clear) begin
        digits_closed <= 1'b0;
      end
      if (cmd.dist_take) begin
        if (!digits_closed && is_digit) begin
          distance_acc <= (dist_prod > DPW'(lztd_pkg::DIST_MAX)) ?
                          lztd_pkg::DIST_MAX : lztd_pkg::DIST_W'(dist_prod);
        end else begin
          digits_closed <= 1'b1;
        end
      end
      if (cmd.len_take) begin
        if (!digits_closed && is_digit) begin
          length_acc <= (len_prod > LPW'(lztd_pkg::LEN_MAX)) ?
                        lztd_pkg::LEN_MAX : lztd_pkg::LEN_W'(len_prod);
        end else begin
          digits_closed <= 1'b1;
        end
      end
    end
  end

  // Copy sequencing registers and last stored byte.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd <= ram_raddr;
    end
    if (cmd.copy_start) begin
      count       <= CNTW'(len_eff);
      copy_status <= len_long ? lztd_pkg::STAT_TRUNC : lztd_pkg::STAT_OK;
      dist_one    <= (distance_acc == lztd_pkg::DIST_W'(1));
    end else if (cmd.copy_step) begin
      count <= count - 1'b1;
    end
    if (store) begin
      last_byte <= store_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.lit_store || cmd.err_emit || cmd.copy_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lit_store) begin
      out_item.out_byte <= in_byte;
      out_item.run_last <= 1'b1;
      out_item.status   <= lztd_pkg::STAT_OK;
    end else if (cmd.err_emit) begin
      out_item.out_byte <= '0;
      out_item.run_last <= 1'b1;
      out_item.status   <= lztd_pkg::STAT_BAD_DIST;
    end else if (cmd.copy_step) begin
      out_item.out_byte <= copy_data;
      out_item.run_last <= sts.copy_last;
      out_item.status   <= copy_status;
    end
  end

endmodule

>>> bench/tb.sv
// Testbench for lz77_text_token_decoder: feeds compressed text one byte per item
// and checks every decoded item against a behavioral decoder kept in this file or a typed-in result.
// Depends on lztd_pkg, lztd_chan_if and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = lztd_pkg::WINDOW_SIZE_DEF;
  localparam int RUN          = lztd_pkg::MAX_RUN_DEF;
  localparam int PTR_W        = $clog2(WIN);
  localparam int RANDOM_ITEMS = 290;
  localparam int IDLE_PCT     = 8;
  localparam int DRAIN_CYCLES = 10;
  // Worst case is far below this: every byte a 64-byte copy under receiver stalls.
  localparam int CYCLE_LIMIT  = 500000;

  localparam lztd_pkg::out_item_t NO_TEXT       = '0;
  localparam lztd_pkg::out_item_t BAD_BACK_TEXT = '{out_byte: 8'h00, run_last: 1'b1,
                                                    status: lztd_pkg::STAT_BAD_DIST};
  localparam lztd_pkg::out_item_t NUL_TEXT      = '{out_byte: 8'h00, run_last: 1'b1,
                                                    status: lztd_pkg::STAT_OK};
  localparam lztd_pkg::out_item_t ONES_TEXT     = '{out_byte: 8'hFF, run_last: 1'b1,
                                                    status: lztd_pkg::STAT_OK};

  // One directed item: the byte, and a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]          in_byte;
    logic                typed;
    lztd_pkg::out_item_t want;
  } token_row_t;

  token_row_t directed_rows [27] = '{
    // Empty window: any reference has a bad distance.
    '{lztd_pkg::CH_OPEN, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd1, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_COMMA, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd1, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_CLOSE, 1'b1, BAD_BACK_TEXT},
    // Literal extremes, then an ordinary letter.
    '{8'h00, 1'b1, NUL_TEXT}, '{8'hFF, 1'b1, ONES_TEXT}, '{8'h41, 1'b0, NO_TEXT},
    // Empty distance reads as zero.
    '{lztd_pkg::CH_OPEN, 1'b0, NO_TEXT}, '{lztd_pkg::CH_COMMA, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_ZERO + 8'd3, 1'b0, NO_TEXT}, '{lztd_pkg::CH_CLOSE, 1'b1, BAD_BACK_TEXT},
    // Zero length with a good distance: nothing comes out.
    '{lztd_pkg::CH_OPEN, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd1, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_COMMA, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_CLOSE, 1'b0, NO_TEXT},
    // ')' closes the distance digits, the 9 after it is ignored; ',' closes the
    // length 99, which is cut to the run limit; overlapping copy of distance 3.
    '{lztd_pkg::CH_OPEN, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd3, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_CLOSE, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd9, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_COMMA, 1'b0, NO_TEXT}, '{lztd_pkg::CH_ZERO + 8'd9, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_ZERO + 8'd9, 1'b0, NO_TEXT}, '{lztd_pkg::CH_COMMA, 1'b0, NO_TEXT},
    '{lztd_pkg::CH_ZERO + 8'd5, 1'b0, NO_TEXT}, '{lztd_pkg::CH_CLOSE, 1'b0, NO_TEXT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  lztd_chan_if #(.item_t(lztd_pkg::in_item_t))  token_if ();
  lztd_chan_if #(.item_t(lztd_pkg::out_item_t)) text_if ();

  lz77_text_token_decoder #(
    .WINDOW_SIZE(WIN),
    .MAX_RUN    (RUN)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .token(token_if),
    .text (text_if)
  );

  // Decoder state as this bench sees it.
  logic [7:0]                  hist [WIN];
  logic [PTR_W-1:0]            wr_ptr      = '0;
  logic [PTR_W:0]              n_written   = '0;
  lztd_pkg::state_t            mode        = lztd_pkg::S_OUTSIDE;
  logic [lztd_pkg::DIST_W-1:0] back_acc    = '0;
  logic [lztd_pkg::LEN_W-1:0]  span_acc    = '0;
  logic                        digits_done = 1'b0;

  lztd_pkg::out_item_t decoded [$];      // results of the byte just decoded
  lztd_pkg::out_item_t text_expect [$];  // results still owed by the block
  logic [8:0]          burst [$];        // random bytes to send; bit 8 marks an ignored byte

  int n_sent, n_rand, n_checked, n_refs, n_bad, n_trunc, n_err, cycles;

  // Both sides run without idling through this stretch of the stream.
  wire calm = (n_sent >= 150) && (n_sent < 260);

  initial forever #1 clk = ~clk;

  // Fold one digit into a decimal number; the first non-digit closes it.
  function automatic int unsigned add_digit(int unsigned acc, logic [7:0] b,
                                            int unsigned top);
    int unsigned v;
    if (!digits_done && b >= lztd_pkg::CH_ZERO && b <= lztd_pkg::CH_NINE) begin
      v = acc * 10 + (b - lztd_pkg::CH_ZERO);
      return (v > top) ? top : v;
    end
    digits_done = 1'b1;
    return acc;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (n_written < WIN) n_written = n_written + 1'b1;
  endfunction

  // Advance the decoder by one input byte and collect its results in decoded.
  function automatic void decode_byte(logic [7:0] b);
    int unsigned         span;
    logic [1:0]          st;
    lztd_pkg::out_item_t r;
    decoded.delete();
    case (mode)
      lztd_pkg::S_DIST: begin
        if (b == lztd_pkg::CH_COMMA) begin
          mode = lztd_pkg::S_LEN;
          digits_done = 1'b0;
        end else begin
          back_acc = lztd_pkg::DIST_W'(add_digit(back_acc, b, lztd_pkg::DIST_MAX));
        end
      end
      lztd_pkg::S_LEN: begin
        if (b != lztd_pkg::CH_CLOSE) begin
          span_acc = lztd_pkg::LEN_W'(add_digit(span_acc, b, lztd_pkg::LEN_MAX));
        end else begin
          mode = lztd_pkg::S_OUTSIDE;
          digits_done = 1'b0;
          n_refs++;
          if (back_acc == '0 || back_acc > n_written) begin
            decoded.push_back(BAD_BACK_TEXT);
            n_bad++;
          end else begin
            span = span_acc;
            st = lztd_pkg::STAT_OK;
            if (span > RUN) begin
              span = RUN;
              st = lztd_pkg::STAT_TRUNC;
              n_trunc++;
            end
            for (int i = 0; i < span; i++) begin
              // Read behind the write pointer; the copy may feed on itself.
              r.out_byte = hist[PTR_W'(wr_ptr - back_acc)];
              r.run_last = (i == span - 1);
              r.status   = st;
              keep_byte(r.out_byte);
              decoded.push_back(r);
            end
          end
        end
      end
      default: begin
        if (b == lztd_pkg::CH_OPEN) begin
          mode = lztd_pkg::S_DIST;
          back_acc = '0;
          span_acc = '0;
          digits_done = 1'b0;
        end else begin
          mode = lztd_pkg::S_OUTSIDE;
          keep_byte(b);
          r = '{out_byte: b, run_last: 1'b1, status: lztd_pkg::STAT_OK};
          decoded.push_back(r);
        end
      end
    endcase
  endfunction

  // Offer one byte, hold it until taken, then book what it should produce.
  // Entered and left at a falling edge.
  task automatic send_token(logic [7:0] b, logic typed, lztd_pkg::out_item_t want);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      token_if.valid <= 1'b0;
      @(negedge clk);
    end
    token_if.valid <= 1'b1;
    token_if.data.in_byte <= b;
    do @(posedge clk); while (!token_if.ready);
    decode_byte(b);
    if (typed) text_expect.push_back(want);
    else foreach (decoded[i]) text_expect.push_back(decoded[i]);
    n_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come out.
  task automatic hold_until_drained();
    token_if.valid <= 1'b0;
    while (text_expect.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_number(int unsigned v, bit bare);
    string s;
    if (bare) return;
    if ($urandom_range(99) < 10) burst.push_back({1'b0, lztd_pkg::CH_ZERO});
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) burst.push_back({1'b0, s[i]});
  endtask

  // Close a number with a non-digit, often the other delimiter, then add bytes
  // the decoder must ignore until the real delimiter.
  task automatic push_junk(logic [7:0] delim, logic [7:0] other);
    logic [7:0] b;
    if ($urandom_range(99) < 30) b = other;
    else do b = 8'($urandom_range(255));
      while ((b >= lztd_pkg::CH_ZERO && b <= lztd_pkg::CH_NINE) || b == delim);
    burst.push_back({1'b0, b});
    repeat ($urandom_range(3)) begin
      do b = 8'($urandom_range(255)); while (b == delim);
      burst.push_back({1'b1, b});
    end
  endtask

  // Build a literal or a reference; mostly well formed, some broken on purpose.
  task automatic build_burst();
    int unsigned pick, back, span, lim;
    logic [7:0]  lit;
    burst.delete();
    pick = $urandom_range(99);
    if (pick < 35 || n_written == 0) begin
      lit = 8'($urandom_range(255));
      if (lit == lztd_pkg::CH_OPEN) lit = ~lztd_pkg::CH_OPEN;
      burst.push_back({1'b0, lit});
      return;
    end
    pick = $urandom_range(99);
    lim = (n_written < 16) ? n_written : 16;
    if (pick < 70)      back = $urandom_range(lim, 1);
    else if (pick < 80) back = $urandom_range(n_written, 1);
    else if (pick < 85) back = n_written;
    else if (pick < 88) back = n_written + 1;
    else if (pick < 92) back = 0;
    else if (pick < 96) back = n_written + $urandom_range(500, 2);
    else                back = $urandom_range(999999, 10000);
    pick = $urandom_range(99);
    if (pick < 40)      span = $urandom_range(12, 1);
    else if (pick < 55) span = $urandom_range(63, 13);
    else if (pick < 93) span = $urandom_range(127, 64);
    else if (pick < 97) span = 0;
    else                span = $urandom_range(999999, 128);
    burst.push_back({1'b0, lztd_pkg::CH_OPEN});
    push_number(back, back == 0 && $urandom_range(1));
    if ($urandom_range(99) < 12) push_junk(lztd_pkg::CH_COMMA, lztd_pkg::CH_CLOSE);
    burst.push_back({1'b0, lztd_pkg::CH_COMMA});
    push_number(span, span == 0 && $urandom_range(1));
    if ($urandom_range(99) < 12) push_junk(lztd_pkg::CH_CLOSE, lztd_pkg::CH_COMMA);
    burst.push_back({1'b0, lztd_pkg::CH_CLOSE});
  endtask

  // Receiver: stall at random, except through the calm stretch.
  always @(negedge clk) text_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // Compare each taken text item with the oldest result still owed.
  always @(posedge clk) begin : text_check
    lztd_pkg::out_item_t want;
    if (!rst && text_if.valid && text_if.ready) begin
      n_checked++;
      if (text_expect.size() == 0) begin
        $error("unexpected text item: out_byte %0h run_last %0b status %0d",
               text_if.data.out_byte, text_if.data.run_last, text_if.data.status);
        n_err++;
      end else begin
        want = text_expect.pop_front();
        if (text_if.data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, text_if.data.out_byte);
          n_err++;
        end
        if (text_if.data.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, text_if.data.run_last);
          n_err++;
        end
        if (text_if.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, text_if.data.status);
          n_err++;
        end
      end
    end
  end

  // Watchdog: stop a run that hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles,
               text_expect.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    bit paused;
    token_if.valid = 1'b0;
    token_if.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: walk the table.
    foreach (directed_rows[i])
      send_token(directed_rows[i].in_byte, directed_rows[i].typed, directed_rows[i].want);
    hold_until_drained();

    // Random part, with one full drain halfway through.
    while (n_rand < RANDOM_ITEMS) begin
      if (n_rand >= RANDOM_ITEMS / 2 && !paused) begin
        hold_until_drained();
        paused = 1'b1;
      end
      build_burst();
      foreach (burst[k]) begin
        send_token(burst[k][7:0], 1'b0, NO_TEXT);
        if (!burst[k][8]) n_rand++;
      end
    end
    token_if.valid <= 1'b0;

    // Wait for the owed results, then keep watching for anything stray.
    while (text_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d token bytes (%0d directed), checked %0d text bytes",
             n_sent, $size(directed_rows), n_checked);
    $display("Closed %0d references: %0d bad distances, %0d runs cut to %0d",
             n_refs, n_bad, n_trunc, RUN);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
